>>> hw/rtl/stap_pkg.sv
package stap_pkg;

    // sample and register widths
    localparam int SAMPLE_W  = 32;
    localparam int RATIO_W   = 9;
    localparam int N_W       = 11;
    localparam int BIN_OUT_W = 10;

    // group sum holds up to 2^RATIO_W - 1 samples
    localparam int SUM_W = SAMPLE_W + RATIO_W;
    // unsigned magnitude of the blend numerator (can reach 2^41)
    localparam int MAG_W = SUM_W + 1;
    // signed blend numerator
    localparam int ACC_W = MAG_W + 1;

    localparam int DIV_CNT_W = $clog2(MAG_W + 1);
    localparam int MUL_CNT_W = $clog2(N_W + 1);

    localparam logic [N_W-1:0] AVG_LIMIT_TOP = N_W'(1024);

    // configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 11;

    localparam logic [CFG_IDX_W-1:0] REG_POOL_MODE   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_POOL_RATIO  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_AVG_ENABLE  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_AVG_LIMIT   = 2'd3;

    // stream widths
    localparam int S_TDATA_W = 32;
    localparam int M_FIELDS_W = BIN_OUT_W + SAMPLE_W + N_W;
    localparam int M_TDATA_W = ((M_FIELDS_W + 7) / 8) * 8;
    localparam int M_PAD_W   = M_TDATA_W - M_FIELDS_W;

    // status of a serial arithmetic unit
    typedef struct packed {
        logic busy;
        logic done;
    } unit_sts_t;

endpackage

>>> hw/rtl/stap_sdiv.sv
// restoring divider, one quotient bit per cycle
module stap_sdiv (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          start,
    input  logic [stap_pkg::MAG_W-1:0]    dividend,
    input  logic [stap_pkg::N_W-1:0]      divisor,
    output stap_pkg::unit_sts_t           sts,
    output logic [stap_pkg::MAG_W-1:0]    quotient
);

    logic [stap_pkg::MAG_W-1:0]     quo_reg;
    logic [stap_pkg::N_W-1:0]       rem_reg;
    logic [stap_pkg::N_W-1:0]       rem_next;
    logic [stap_pkg::N_W-1:0]       den_reg;
    logic [stap_pkg::DIV_CNT_W-1:0] cnt_reg;
    logic                           busy_reg;
    logic                           done_reg;
    logic [stap_pkg::N_W:0]         trial;
    logic [stap_pkg::N_W:0]         diff;
    logic                           qbit;

    always_comb begin
        trial    = {rem_reg, quo_reg[stap_pkg::MAG_W-1]};
        diff     = trial - {1'b0, den_reg};
        qbit     = (trial >= {1'b0, den_reg});
        rem_next = qbit ? diff[stap_pkg::N_W-1:0] : trial[stap_pkg::N_W-1:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            quo_reg  <= '0;
            rem_reg  <= '0;
            den_reg  <= '0;
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                quo_reg  <= dividend;
                rem_reg  <= '0;
                den_reg  <= divisor;
                cnt_reg  <= stap_pkg::DIV_CNT_W'(stap_pkg::MAG_W);
                busy_reg <= 1'b1;
            end else if (busy_reg) begin
                rem_reg <= rem_next;
                quo_reg <= {quo_reg[stap_pkg::MAG_W-2:0], qbit};
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == stap_pkg::DIV_CNT_W'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign sts.busy = busy_reg;
    assign sts.done = done_reg;
    assign quotient = quo_reg;

endmodule

>>> hw/rtl/stap_smul.sv
// shift-add multiplier, one multiplier bit per cycle, msb first
module stap_smul (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             start,
    input  logic signed [stap_pkg::SAMPLE_W-1:0] mcand,
    input  logic [stap_pkg::N_W-1:0]         mplier,
    output stap_pkg::unit_sts_t              sts,
    output logic signed [stap_pkg::ACC_W-1:0] product
);

    logic signed [stap_pkg::ACC_W-1:0]    acc_reg;
    logic signed [stap_pkg::ACC_W-1:0]    addend;
    logic signed [stap_pkg::SAMPLE_W-1:0] mc_reg;
    logic [stap_pkg::N_W-1:0]             mp_reg;
    logic [stap_pkg::MUL_CNT_W-1:0]       cnt_reg;
    logic                                 busy_reg;
    logic                                 done_reg;

    always_comb begin
        addend = mp_reg[stap_pkg::N_W-1] ? stap_pkg::ACC_W'(mc_reg) : '0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            acc_reg  <= '0;
            mc_reg   <= '0;
            mp_reg   <= '0;
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                acc_reg  <= '0;
                mc_reg   <= mcand;
                mp_reg   <= mplier;
                cnt_reg  <= stap_pkg::MUL_CNT_W'(stap_pkg::N_W);
                busy_reg <= 1'b1;
            end else if (busy_reg) begin
                acc_reg <= (acc_reg <<< 1) + addend;
                mp_reg  <= {mp_reg[stap_pkg::N_W-2:0], 1'b0};
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == stap_pkg::MUL_CNT_W'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign sts.busy = busy_reg;
    assign sts.done = done_reg;
    assign product  = acc_reg;

endmodule

>>> hw/rtl/spectrum_trace_pool_and_average_core.sv
// a sample that does not close a group is added into it in ST_IDLE; a closing sample passes
//   ST_POOL, ST_MEAN for the mean divide in mean mode, ST_BLEND, then ST_MUL, ST_ACC and
//   ST_DIV for the trace blend when averaging is on, then ST_OUT to the output register
// throughput: one closing sample in flight at a time, as s_tready is low outside ST_IDLE
// reset: aresetn synchronous active low; clears group, bin position, average count and
//   config to defaults; trace memory is not cleared and holds data only once written
module spectrum_trace_pool_and_average_core #(
    parameter int DISPLAY_BINS = 1024,
    parameter int MAX_RATIO    = 256
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    // input stream
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [stap_pkg::S_TDATA_W-1:0]    s_tdata,   // [31:0] magnitude
    // result stream
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [stap_pkg::M_TDATA_W-1:0]    m_tdata,   // [9:0] bin_index, [41:10] bin_value,
                                                         // [52:42] sweeps_averaged, rest zero
    output logic                              m_tlast,   // last_bin
    // configuration write port
    input  logic                              cfg_we,
    input  logic [stap_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [stap_pkg::CFG_DATA_W-1:0]   cfg_wdata
);

    localparam int BIN_W = $clog2(DISPLAY_BINS);

    typedef enum logic [2:0] {
        ST_IDLE,   // taking samples
        ST_POOL,   // group closed: pick max or kick off mean divide
        ST_MEAN,   // waiting on mean divide
        ST_BLEND,  // update count, kick off trace multiply; straight to output when averaging is off
        ST_MUL,    // waiting on multiply
        ST_ACC,    // numerator ready, kick off blend divide
        ST_DIV,    // waiting on blend divide
        ST_OUT     // hand result to output register
    } state_t;

    state_t state_reg;

    // configuration registers
    logic                         pool_mode_reg;
    logic [stap_pkg::RATIO_W-1:0] pool_ratio_reg;
    logic                         avg_en_reg;
    logic [stap_pkg::N_W-1:0]     avg_limit_reg;

    // pooling state
    logic signed [stap_pkg::SUM_W-1:0]    group_sum_reg;
    logic signed [stap_pkg::SAMPLE_W-1:0] group_max_reg;
    logic [stap_pkg::RATIO_W-1:0]         group_fill_reg;
    logic [BIN_W-1:0]                     display_bin_reg;

    // averaging state
    logic                     trace_valid_reg;
    logic [stap_pkg::N_W-1:0] count_reg;
    logic [stap_pkg::N_W-1:0] swept_reg;

    // per-bin working registers
    logic [BIN_W-1:0]                     bin_reg;
    logic                                 last_reg;
    logic signed [stap_pkg::SAMPLE_W-1:0] val_reg;
    logic signed [stap_pkg::ACC_W-1:0]    acc_reg;
    logic                                 neg_reg;

    // output register
    logic                                 m_tvalid_reg;
    logic [stap_pkg::BIN_OUT_W-1:0]       m_bin_reg;
    logic [stap_pkg::SAMPLE_W-1:0]        m_value_reg;
    logic                                 m_last_reg;
    logic [stap_pkg::N_W-1:0]             m_swept_reg;

    // trace memory, registered read at the current bin
    logic [stap_pkg::SAMPLE_W-1:0] trace_mem [DISPLAY_BINS];
    logic [stap_pkg::SAMPLE_W-1:0] rd_data_reg;
    logic                          mem_we;
    logic [stap_pkg::SAMPLE_W-1:0] mem_wdata;

    // serial units
    logic                                 div_start;
    logic [stap_pkg::MAG_W-1:0]           div_dividend;
    logic [stap_pkg::N_W-1:0]             div_divisor;
    stap_pkg::unit_sts_t                  div_sts;
    logic [stap_pkg::MAG_W-1:0]           div_quot;
    logic                                 mul_start;
    logic [stap_pkg::N_W-1:0]             mul_mplier;
    stap_pkg::unit_sts_t                  mul_sts;
    logic signed [stap_pkg::ACC_W-1:0]    mul_prod;

    // combinational helpers
    logic                                 s_req;
    logic [stap_pkg::RATIO_W-1:0]         eff_ratio;
    logic [stap_pkg::N_W-1:0]             eff_limit;
    logic signed [stap_pkg::SAMPLE_W-1:0] sample;
    logic signed [stap_pkg::SUM_W-1:0]    sum_next;
    logic signed [stap_pkg::SAMPLE_W-1:0] max_next;
    logic [stap_pkg::RATIO_W-1:0]         fill_inc;
    logic                                 group_done;
    logic [stap_pkg::SUM_W-1:0]           sum_abs;
    logic [stap_pkg::ACC_W-1:0]           acc_abs;
    logic [stap_pkg::SAMPLE_W-1:0]        quot_signed;
    logic [stap_pkg::N_W-1:0]             count_inc;
    logic [stap_pkg::N_W-1:0]             count_sel;
    logic [stap_pkg::N_W-1:0]             n_sel;
    logic                                 out_free;

    assign s_tready = (state_reg == ST_IDLE);
    assign s_req    = s_tvalid && s_tready;
    assign out_free = !m_tvalid_reg || m_tready;

    always_comb begin
        // zero ratio acts as one, oversize ratio saturates
        if (pool_ratio_reg == '0) begin
            eff_ratio = stap_pkg::RATIO_W'(1);
        end else if (32'(pool_ratio_reg) > MAX_RATIO) begin
            eff_ratio = stap_pkg::RATIO_W'(MAX_RATIO);
        end else begin
            eff_ratio = pool_ratio_reg;
        end

        if (avg_limit_reg == '0) begin
            eff_limit = stap_pkg::N_W'(1);
        end else if (avg_limit_reg > stap_pkg::AVG_LIMIT_TOP) begin
            eff_limit = stap_pkg::AVG_LIMIT_TOP;
        end else begin
            eff_limit = avg_limit_reg;
        end

        sample     = $signed(s_tdata[stap_pkg::SAMPLE_W-1:0]);
        sum_next   = group_sum_reg + stap_pkg::SUM_W'(sample);
        max_next   = (sample > group_max_reg) ? sample : group_max_reg;
        fill_inc   = group_fill_reg + 1'b1;
        group_done = (fill_inc >= eff_ratio);

        sum_abs     = group_sum_reg[stap_pkg::SUM_W-1] ? stap_pkg::SUM_W'(-group_sum_reg)
                                                       : stap_pkg::SUM_W'(group_sum_reg);
        acc_abs     = acc_reg[stap_pkg::ACC_W-1] ? stap_pkg::ACC_W'(-acc_reg)
                                                 : stap_pkg::ACC_W'(acc_reg);
        quot_signed = neg_reg ? (~div_quot[stap_pkg::SAMPLE_W-1:0] + 1'b1)
                              : div_quot[stap_pkg::SAMPLE_W-1:0];

        // sweep start bumps the average count, capped at the limit; one while no trace is valid
        count_inc = count_reg + 1'b1;
        if (bin_reg == '0) begin
            if (!trace_valid_reg) begin
                count_sel = stap_pkg::N_W'(1);
            end else begin
                count_sel = (count_inc < eff_limit) ? count_inc : eff_limit;
            end
        end else begin
            count_sel = count_reg;
        end
        n_sel      = (count_sel == '0) ? stap_pkg::N_W'(1) : count_sel;
        mul_mplier = n_sel - 1'b1;

        // one divider serves the mean and the blend
        div_start    = 1'b0;
        div_dividend = {1'b0, sum_abs};
        div_divisor  = stap_pkg::N_W'(eff_ratio);
        if (state_reg == ST_POOL && pool_mode_reg) begin
            div_start = 1'b1;
        end else if (state_reg == ST_ACC) begin
            div_start    = 1'b1;
            div_dividend = acc_abs[stap_pkg::MAG_W-1:0];
            div_divisor  = count_reg == '0 ? stap_pkg::N_W'(1) : count_reg;
        end

        mul_start = (state_reg == ST_BLEND) && avg_en_reg;

        mem_we    = (state_reg == ST_DIV) && div_sts.done;
        mem_wdata = quot_signed;
    end

    stap_sdiv u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .sts      (div_sts),
        .quotient (div_quot)
    );

    stap_smul u_mul (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (mul_start),
        .mcand   ($signed(rd_data_reg)),
        .mplier  (mul_mplier),
        .sts     (mul_sts),
        .product (mul_prod)
    );

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            trace_mem[bin_reg] <= mem_wdata;
        end
        rd_data_reg <= trace_mem[bin_reg];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= ST_IDLE;
            pool_mode_reg   <= 1'b0;
            pool_ratio_reg  <= stap_pkg::RATIO_W'(1);
            avg_en_reg      <= 1'b0;
            avg_limit_reg   <= stap_pkg::N_W'(1);
            group_sum_reg   <= '0;
            group_max_reg   <= '0;
            group_fill_reg  <= '0;
            display_bin_reg <= '0;
            trace_valid_reg <= 1'b0;
            count_reg       <= '0;
            swept_reg       <= '0;
            bin_reg         <= '0;
            last_reg        <= 1'b0;
            val_reg         <= '0;
            acc_reg         <= '0;
            neg_reg         <= 1'b0;
            m_tvalid_reg    <= 1'b0;
            m_bin_reg       <= '0;
            m_value_reg     <= '0;
            m_last_reg      <= 1'b0;
            m_swept_reg     <= '0;
        end else begin
            if (m_tvalid_reg && m_tready) begin
                m_tvalid_reg <= 1'b0;
            end

            unique case (state_reg)
                ST_IDLE: begin
                    if (s_req) begin
                        group_sum_reg <= sum_next;
                        group_max_reg <= max_next;
                        if (group_done) begin
                            group_fill_reg <= '0;
                            bin_reg        <= display_bin_reg;
                            last_reg       <= (display_bin_reg == BIN_W'(DISPLAY_BINS - 1));
                            state_reg      <= ST_POOL;
                        end else begin
                            group_fill_reg <= fill_inc;
                        end
                    end
                end
                ST_POOL: begin
                    // in mean mode the divider takes the sum this cycle, so the group can restart
                    val_reg       <= group_max_reg;
                    neg_reg       <= group_sum_reg[stap_pkg::SUM_W-1];
                    group_sum_reg <= '0;
                    group_max_reg <= '0;
                    state_reg     <= pool_mode_reg ? ST_MEAN : ST_BLEND;
                end
                ST_MEAN: begin
                    if (div_sts.done) begin
                        val_reg   <= $signed(quot_signed);
                        state_reg <= ST_BLEND;
                    end
                end
                ST_BLEND: begin
                    if (avg_en_reg) begin
                        count_reg <= count_sel;
                        state_reg <= ST_MUL;
                    end else begin
                        swept_reg <= '0;
                        state_reg <= ST_OUT;
                    end
                end
                ST_MUL: begin
                    if (mul_sts.done) begin
                        acc_reg   <= mul_prod + stap_pkg::ACC_W'(val_reg);
                        state_reg <= ST_ACC;
                    end
                end
                ST_ACC: begin
                    neg_reg   <= acc_reg[stap_pkg::ACC_W-1];
                    state_reg <= ST_DIV;
                end
                ST_DIV: begin
                    if (div_sts.done) begin
                        val_reg   <= $signed(quot_signed);
                        swept_reg <= count_reg;
                        if (last_reg && count_reg != '0) begin
                            trace_valid_reg <= 1'b1;
                        end
                        state_reg <= ST_OUT;
                    end
                end
                ST_OUT: begin
                    if (out_free) begin
                        m_tvalid_reg    <= 1'b1;
                        m_bin_reg       <= stap_pkg::BIN_OUT_W'(bin_reg);
                        m_value_reg     <= val_reg;
                        m_last_reg      <= last_reg;
                        m_swept_reg     <= swept_reg;
                        display_bin_reg <= last_reg ? '0 : bin_reg + 1'b1;
                        state_reg       <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase

            // register writes; the user must issue them only while the block is idle, the block does not enforce it
            if (cfg_we) begin
                unique case (cfg_index)
                    stap_pkg::REG_POOL_MODE: begin
                        pool_mode_reg <= cfg_wdata[0];
                    end
                    stap_pkg::REG_POOL_RATIO: begin
                        // restart the sweep, trace is kept
                        pool_ratio_reg  <= cfg_wdata[stap_pkg::RATIO_W-1:0];
                        group_sum_reg   <= '0;
                        group_max_reg   <= '0;
                        group_fill_reg  <= '0;
                        display_bin_reg <= '0;
                    end
                    stap_pkg::REG_AVG_ENABLE: begin
                        avg_en_reg      <= cfg_wdata[0];
                        count_reg       <= '0;
                        trace_valid_reg <= 1'b0;
                    end
                    stap_pkg::REG_AVG_LIMIT: begin
                        avg_limit_reg   <= cfg_wdata[stap_pkg::N_W-1:0];
                        count_reg       <= '0;
                        trace_valid_reg <= 1'b0;
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tlast  = m_last_reg;
    assign m_tdata  = {{stap_pkg::M_PAD_W{1'b0}}, m_swept_reg, m_value_reg, m_bin_reg};

endmodule

>>> bench/spectrum_trace_pool_and_average_checker.sv
`timescale 1ns / 100ps

module spectrum_trace_pool_and_average_checker #(
    parameter int DISPLAY_BINS = 1024,
    parameter int MAX_RATIO    = 256
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_tvalid,
    input  logic                                s_tready,
    input  logic [stap_pkg::S_TDATA_W-1:0]      s_tdata,   // [31:0] magnitude
    input  logic                                m_tvalid,
    input  logic                                m_tready,
    input  logic [stap_pkg::M_TDATA_W-1:0]      m_tdata,   // [9:0] bin_index, [41:10] bin_value,
                                                           // [52:42] sweeps_averaged, rest zero
    input  logic                                m_tlast,   // last_bin
    input  logic                                cfg_we,
    input  logic [stap_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [stap_pkg::CFG_DATA_W-1:0]     cfg_wdata,
    output int                                  fail_count,
    output int                                  pending
);

    localparam int BIN_W    = stap_pkg::BIN_OUT_W;
    localparam int VALUE_W  = stap_pkg::SAMPLE_W;
    localparam int COUNT_W  = stap_pkg::N_W;
    localparam int RATIO_W  = stap_pkg::RATIO_W;
    localparam int VALUE_LO = BIN_W;
    localparam int COUNT_LO = BIN_W + VALUE_W;
    localparam int FIELDS_W = stap_pkg::M_FIELDS_W;
    localparam int TDATA_W  = stap_pkg::M_TDATA_W;

    typedef struct {
        logic [BIN_W-1:0]   bin;
        logic [VALUE_W-1:0] value;
        logic               last;
        logic [COUNT_W-1:0] count;
    } bin_result_t;

    bin_result_t expected_bins[$];
    int          reports;

    // configuration as last written
    logic               pool_mean;
    logic [RATIO_W-1:0] ratio_reg;
    logic               avg_on;
    logic [COUNT_W-1:0] limit_reg;

    // pooling and averaging state
    longint      group_sum;
    int          group_max;
    int unsigned group_fill;
    int unsigned bin_pos;
    int          trace_mem [DISPLAY_BINS];
    bit          trace_ok;
    int unsigned sweep_count;

    function automatic int unsigned ratio_now();
        if (ratio_reg == 0) return 1;
        if (ratio_reg > MAX_RATIO) return MAX_RATIO;
        return ratio_reg;
    endfunction

    function automatic int unsigned limit_now();
        if (limit_reg == 0) return 1;
        if (limit_reg > stap_pkg::AVG_LIMIT_TOP) return stap_pkg::AVG_LIMIT_TOP;
        return limit_reg;
    endfunction

    function automatic void restart_group();
        group_sum  = 0;
        group_max  = 0;
        group_fill = 0;
    endfunction

    function automatic void note_failure(input string msg);
        fail_count++;
        if (reports < 10) begin
            $display("mismatch at %0t: %s", $time, msg);
            reports++;
        end
    endfunction

    task automatic pool_and_blend(input logic [VALUE_W-1:0] raw);
        longint      x;
        longint      pooled;
        longint      n;
        longint      acc;
        int unsigned bin;
        int unsigned lim;
        bin_result_t r;
        x = longint'($signed(raw));
        group_sum += x;
        if (x > longint'(group_max)) group_max = int'(x);
        group_fill++;
        if (group_fill < ratio_now()) return;

        pooled = pool_mean ? group_sum / longint'(ratio_now()) : longint'(group_max);
        restart_group();

        bin = (bin_pos >= DISPLAY_BINS) ? 0 : bin_pos;
        r.last  = (bin == DISPLAY_BINS - 1);
        r.count = '0;
        if (avg_on) begin
            // sweep start picks the divisor for the whole sweep
            if (bin == 0) begin
                if (!trace_ok) begin
                    sweep_count = 1;
                end else begin
                    lim = limit_now();
                    sweep_count = (sweep_count + 1 < lim) ? sweep_count + 1 : lim;
                end
            end
            n = (sweep_count == 0) ? 1 : longint'(sweep_count);
            acc = longint'(trace_mem[bin]) * (n - 1) + pooled;
            pooled = acc / n;
            trace_mem[bin] = int'(pooled);
            r.count = COUNT_W'(sweep_count);
            if (r.last && sweep_count != 0) trace_ok = 1'b1;
        end
        bin_pos = r.last ? 0 : bin + 1;

        r.bin   = BIN_W'(bin);
        r.value = VALUE_W'(pooled);
        expected_bins.push_back(r);
    endtask

    task automatic check_bin(input logic [TDATA_W-1:0] data, input logic last);
        bin_result_t want;
        if (expected_bins.size() == 0) begin
            note_failure($sformatf("result with none expected: tdata %h tlast %b", data, last));
            return;
        end
        want = expected_bins.pop_front();
        if (data[BIN_W-1:0] !== want.bin || data[VALUE_LO +: VALUE_W] !== want.value
                || data[COUNT_LO +: COUNT_W] !== want.count || last !== want.last
                || (data >> FIELDS_W) !== '0) begin
            note_failure($sformatf({"expected/actual: bin_index %0d/%0d bin_value %h/%h ",
                "last_bin %b/%b sweeps_averaged %0d/%0d padding 0/%h"},
                want.bin, data[BIN_W-1:0], want.value, data[VALUE_LO +: VALUE_W],
                want.last, last, want.count, data[COUNT_LO +: COUNT_W], data >> FIELDS_W));
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            pool_mean   = 1'b0;
            ratio_reg   = RATIO_W'(1);
            avg_on      = 1'b0;
            limit_reg   = COUNT_W'(1);
            restart_group();
            bin_pos     = 0;
            trace_ok    = 1'b0;
            sweep_count = 0;
            fail_count  = 0;
            reports     = 0;
            expected_bins.delete();
        end else begin
            if (cfg_we) begin
                case (cfg_index)
                    stap_pkg::REG_POOL_MODE: begin
                        pool_mean = cfg_wdata[0];
                    end
                    stap_pkg::REG_POOL_RATIO: begin
                        ratio_reg = cfg_wdata[RATIO_W-1:0];
                        restart_group();
                        bin_pos = 0;
                    end
                    stap_pkg::REG_AVG_ENABLE: begin
                        avg_on      = cfg_wdata[0];
                        sweep_count = 0;
                        trace_ok    = 1'b0;
                    end
                    stap_pkg::REG_AVG_LIMIT: begin
                        limit_reg   = cfg_wdata[COUNT_W-1:0];
                        sweep_count = 0;
                        trace_ok    = 1'b0;
                    end
                    default: begin
                    end
                endcase
            end
            if (s_tvalid && s_tready) pool_and_blend(s_tdata[VALUE_W-1:0]);
            if (m_tvalid && m_tready) check_bin(m_tdata, m_tlast);
        end
        pending <= expected_bins.size();
    end

endmodule

>>> bench/spectrum_trace_pool_and_average_core_test.sv
`timescale 1ns / 100ps

module spectrum_trace_pool_and_average_core_test;

    localparam int DISPLAY_BINS = 1024;
    localparam int MAX_RATIO    = 256;

    // allowance for the slowest closing sample to finish, with margin
    localparam int SETTLE_CYCLES = 120;

    // pooling modes as written to the mode register
    localparam int unsigned POOL_MAX  = 0;
    localparam int unsigned POOL_MEAN = 1;

    // register groups written at the start of a phase
    localparam bit [3:0] POOL_REGS  = (4'b1 << stap_pkg::REG_POOL_MODE)
                                    | (4'b1 << stap_pkg::REG_POOL_RATIO);
    localparam bit [3:0] AVG_REGS   = (4'b1 << stap_pkg::REG_AVG_ENABLE)
                                    | (4'b1 << stap_pkg::REG_AVG_LIMIT);
    localparam bit [3:0] ALL_REGS   = POOL_REGS | AVG_REGS;
    localparam bit [3:0] LIMIT_REG  = 4'b1 << stap_pkg::REG_AVG_LIMIT;

    // extremes of the magnitude, one bin each with max pooling over one sample
    localparam logic [31:0] EDGE_VALUES [12] = '{
        32'h0000_0000, 32'h7fff_ffff, 32'h8000_0000, 32'hffff_ffff,
        32'h0000_0001, 32'haaaa_aaaa, 32'h5555_5555, 32'h0001_0000,
        32'hffff_0000, 32'h7fff_fffe, 32'h8000_0001, 32'h0000_8000
    };

    // pairs for the mean over two samples: truncation toward zero both ways,
    // sums beyond the 32-bit range at both ends, and a full-range mix
    localparam logic [31:0] MEAN_PAIRS [12] = '{
        32'hffff_fffd, 32'h0000_0000,
        32'h0000_0003, 32'h0000_0000,
        32'h7fff_ffff, 32'h7fff_ffff,
        32'h8000_0000, 32'h8000_0000,
        32'h8000_0000, 32'h7fff_ffff,
        32'hffff_ffff, 32'hffff_fffe
    };

    logic                             aclk      = 1'b0;
    logic                             aresetn   = 1'b0;
    logic                             s_tvalid  = 1'b0;
    logic                             s_tready;
    logic [stap_pkg::S_TDATA_W-1:0]   s_tdata   = '0;    // [31:0] magnitude
    logic                             m_tvalid;
    logic                             m_tready  = 1'b0;
    logic [stap_pkg::M_TDATA_W-1:0]   m_tdata;           // [9:0] bin_index, [41:10] bin_value,
                                                         // [52:42] sweeps_averaged, rest zero
    logic                             m_tlast;           // last_bin
    logic                             cfg_we    = 1'b0;
    logic [stap_pkg::CFG_IDX_W-1:0]   cfg_index = '0;
    logic [stap_pkg::CFG_DATA_W-1:0]  cfg_wdata = '0;

    int fail_count;
    int pending;
    int stall_left = 0;
    bit quiet      = 1'b0;   // no idling on either side once set

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    spectrum_trace_pool_and_average_core #(
        .DISPLAY_BINS (DISPLAY_BINS),
        .MAX_RATIO    (MAX_RATIO)
    ) dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    spectrum_trace_pool_and_average_checker #(
        .DISPLAY_BINS (DISPLAY_BINS),
        .MAX_RATIO    (MAX_RATIO)
    ) u_checker (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tlast    (m_tlast),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_wdata  (cfg_wdata),
        .fail_count (fail_count),
        .pending    (pending)
    );

    // result side back-pressure: m_tready drops in random stall bursts
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready   <= 1'b0;
            stall_left <= 0;
        end else if (stall_left > 0) begin
            m_tready   <= 1'b0;
            stall_left <= stall_left - 1;
        end else if (!quiet && $urandom_range(0, 5) == 0) begin
            m_tready   <= 1'b0;
            stall_left <= $urandom_range(0, 8);
        end else begin
            m_tready <= 1'b1;
        end
    end

    // mix of full-range words, small values around zero and the extremes
    function automatic logic [31:0] random_magnitude();
        logic [31:0] r = $urandom;
        case ($urandom_range(0, 9))
            0:       return 32'h7fff_ffff;
            1:       return 32'h8000_0000;
            2:       return r[0] ? 32'hffff_ffff : 32'h0000_0000;
            3, 4:    return {{14{r[17]}}, r[17:0]};
            5, 6:    return {{8{r[23]}}, r[23:0]};
            default: return r;
        endcase
    endfunction

    // one request on the sample stream, with an occasional gap in front
    task automatic send_magnitude(input logic [31:0] magnitude);
        if (!quiet && $urandom_range(0, 4) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= magnitude;
        do @(posedge aclk); while (!s_tready);
    endtask

    task automatic write_reg(input logic [stap_pkg::CFG_IDX_W-1:0] index,
                             input int unsigned value);
        cfg_we    <= 1'b1;
        cfg_index <= index;
        cfg_wdata <= stap_pkg::CFG_DATA_W'(value);
        @(posedge aclk);
    endtask

    // hold off until every predicted bin is out, then idle for the settle margin
    task automatic settle();
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic run_phase(input bit [3:0] regs, input int unsigned mode, ratio, avg, limit,
                             input int requests);
        settle();
        if (regs[stap_pkg::REG_POOL_MODE])  write_reg(stap_pkg::REG_POOL_MODE, mode);
        if (regs[stap_pkg::REG_POOL_RATIO]) write_reg(stap_pkg::REG_POOL_RATIO, ratio);
        if (regs[stap_pkg::REG_AVG_ENABLE]) write_reg(stap_pkg::REG_AVG_ENABLE, avg);
        if (regs[stap_pkg::REG_AVG_LIMIT])  write_reg(stap_pkg::REG_AVG_LIMIT, limit);
        cfg_we <= 1'b0;
        repeat (requests) send_magnitude(random_magnitude());
        s_tvalid <= 1'b0;
    endtask

    initial begin
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;

        // reset settings: max pooling over one sample, averaging off;
        // negative samples must come out as zero
        foreach (EDGE_VALUES[i]) send_magnitude(EDGE_VALUES[i]);
        s_tvalid <= 1'b0;

        // mean over two samples
        settle();
        write_reg(stap_pkg::REG_POOL_MODE, POOL_MEAN);
        write_reg(stap_pkg::REG_POOL_RATIO, 2);
        cfg_we <= 1'b0;
        foreach (MEAN_PAIRS[i]) send_magnitude(MEAN_PAIRS[i]);
        s_tvalid <= 1'b0;

        // pooling without averaging: odd ratio, zero ratio taken as one,
        // and an over-range ratio saturating to the largest ratio
        run_phase(POOL_REGS, POOL_MAX,  3,   0, 0, 60);
        run_phase(POOL_REGS, POOL_MEAN, 0,   0, 0, 40);
        run_phase(POOL_REGS, POOL_MEAN, 511, 0, 0, 260);

        // averaging with a zero limit (taken as one) over a partial sweep
        run_phase(ALL_REGS, POOL_MEAN, 7, 1, 0, 70);

        // one sample per bin: the first sweep copies bins in with n = 1
        run_phase(ALL_REGS, POOL_MAX, 1, 1, 2, 150);

        // limit write in the middle of a sweep clears the average: the rest
        // of the sweep reports zero sweeps averaged
        run_phase(LIMIT_REG, POOL_MAX, 1, 1, 2047, 60);

        // tail with no idling on either side, averaging off again
        quiet <= 1'b1;
        run_phase(ALL_REGS, POOL_MAX, 2, 0, 1024, 90);

        settle();
        if (fail_count == 0 && pending == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

    // watchdog, several times the slowest legal run
    initial begin
        #5_000_000;
        $display("Simulation FAILED");
        $finish;
    end

endmodule

>>> filelist.f
hw/rtl/stap_pkg.sv
hw/rtl/stap_sdiv.sv
hw/rtl/stap_smul.sv
hw/rtl/spectrum_trace_pool_and_average_core.sv
bench/spectrum_trace_pool_and_average_checker.sv
bench/spectrum_trace_pool_and_average_core_test.sv
